### hdl/sync_length_xor_frame_parser_defines.svh
// Assertion macros for the sync/length/XOR frame parser.
// Included by the top level; expects clk and arst_n in scope.
`ifndef SYNC_LENGTH_XOR_FRAME_PARSER_DEFINES_SVH
`define SYNC_LENGTH_XOR_FRAME_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define SLXFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check a plain expression on every clock edge outside reset
`define SLXFP_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`else
`define SLXFP_ASSERT(lbl, prop, msg)
`define SLXFP_ASSERT_ALWAYS(lbl, expr, msg)
`endif
`endif

### hdl/slxfp_pkg.sv
// Shared types and constants of the sync/length/XOR frame parser.
// No dependencies; imported by every module of the block.
package slxfp_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 8;

	// Header layout: sync, length, id
	localparam logic [POS_W-1:0] POS_HUNT  = 8'd0;
	localparam logic [POS_W-1:0] POS_LEN   = 8'd1;
	localparam logic [POS_W-1:0] POS_ID    = 8'd2;
	localparam logic [POS_W-1:0] HDR_BYTES = 8'd3;

	localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hA4;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic REG_SYNC = 1'b0;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_BADSUM   = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

	// Class of a record handed from front to back
	typedef enum logic [1:0] {
		CLS_PAYLOAD   = 2'd0,
		CLS_FRAME_END = 2'd1,
		CLS_OVERFLOW  = 2'd2
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic              sum_ok;
		logic [BYTE_W-1:0] rx;
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] id;
		logic [BYTE_W-1:0] len;
	} fe_rec_t;

	typedef struct packed {
		logic hunting;
		logic in_header;
	} fe_stat_t;

endpackage

### hdl/slxfp_front.sv
// Front end: tracks frame position, running XOR and header fields per byte.
// Depends on slxfp_pkg; emits one classified record per result-bearing byte.
module slxfp_front import slxfp_pkg::*; #(
	parameter int unsigned POSITION_LIMIT = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] sync_value,
	input  logic              accept,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              rec_wr,
	output fe_rec_t           rec,
	output fe_stat_t          stat
);

	localparam logic [POS_W:0] LIMIT = (POS_W+1)'(POSITION_LIMIT);

	logic [POS_W-1:0]  pos_q, pos_d, pos_inc;
	logic [BYTE_W-1:0] xor_q, xor_d, xor_nx;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] id_q, id_d;
	logic [POS_W:0]    end_pos;
	logic              rec_vld;

	assign xor_nx  = xor_q ^ rx_byte;
	assign pos_inc = pos_q + 1'b1;
	assign end_pos = {1'b0, len_q} + {1'b0, HDR_BYTES};

	// Classify the byte and compute next parser state
	always_comb begin
		pos_d      = pos_q;
		xor_d      = xor_q;
		len_d      = len_q;
		id_d       = id_q;
		rec_vld    = 1'b0;
		rec.cls    = CLS_PAYLOAD;
		rec.sum_ok = (xor_nx == '0);
		rec.rx     = rx_byte;
		rec.pos    = pos_q;
		rec.id     = id_q;
		rec.len    = len_q;
		case (pos_q)
			POS_HUNT: begin
				if (rx_byte == sync_value) begin
					xor_d = rx_byte;
					pos_d = POS_LEN;
				end else begin
					xor_d = '0;
				end
			end
			POS_LEN: begin
				xor_d = xor_nx;
				len_d = rx_byte;
				pos_d = POS_ID;
			end
			POS_ID: begin
				xor_d = xor_nx;
				id_d  = rx_byte;
				pos_d = HDR_BYTES;
			end
			default: begin
				rec_vld = 1'b1;
				if ({1'b0, pos_q} > LIMIT) begin
					rec.cls = CLS_OVERFLOW;
					pos_d   = POS_HUNT;
					xor_d   = '0;
				end else if ({1'b0, pos_q} == end_pos) begin
					rec.cls = CLS_FRAME_END;
					pos_d   = POS_HUNT;
					xor_d   = '0;
				end else begin
					rec.cls = CLS_PAYLOAD;
					pos_d   = pos_inc;
					// drop the checksum when the position wraps to hunting
					xor_d   = (pos_inc == POS_HUNT) ? '0 : xor_nx;
				end
			end
		endcase
	end

	assign rec_wr         = accept && rec_vld;
	assign stat.hunting   = (pos_q == POS_HUNT);
	assign stat.in_header = (pos_q == POS_LEN) || (pos_q == POS_ID);

	// Advance parser state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			xor_q <= '0;
			len_q <= '0;
			id_q  <= '0;
		end else if (accept) begin
			pos_q <= pos_d;
			xor_q <= xor_d;
			len_q <= len_d;
			id_q  <= id_d;
		end
	end

endmodule

### hdl/slxfp_queue.sv
// Short record queue between the front and back ends of the frame parser.
// Depends on slxfp_pkg for the record type.
module slxfp_queue import slxfp_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  fe_rec_t wdata,
	output logic    full,
	input  logic    rd,
	output fe_rec_t rdata,
	output logic    empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fe_rec_t           mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Store an incoming record
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/slxfp_back.sv
// Back end: turns queued records into result items in an output register.
// Depends on slxfp_pkg; drives the result side of the block.
module slxfp_back import slxfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  fe_rec_t           q_rdata,
	output logic              q_rd,
	input  logic              pop,
	output logic              empty,
	output kind_t             kind,
	output logic [BYTE_W-1:0] data_byte,
	output logic [BYTE_W-1:0] payload_index,
	output logic [BYTE_W-1:0] message_id,
	output logic [BYTE_W-1:0] frame_length
);

	logic              vld_q;
	kind_t             kind_q, kind_d;
	logic [BYTE_W-1:0] data_q, data_d;
	logic [BYTE_W-1:0] idx_q, idx_d;
	logic [BYTE_W-1:0] id_q, len_q;
	logic              load;

	// Build the result fields from a record
	always_comb begin
		kind_d = KIND_PAYLOAD;
		data_d = '0;
		idx_d  = '0;
		case (q_rdata.cls)
			CLS_PAYLOAD: begin
				kind_d = KIND_PAYLOAD;
				data_d = q_rdata.rx;
				idx_d  = q_rdata.pos - HDR_BYTES;
			end
			CLS_FRAME_END: begin
				kind_d = q_rdata.sum_ok ? KIND_GOOD : KIND_BADSUM;
				data_d = q_rdata.sum_ok ? q_rdata.rx : '0;
			end
			default: begin
				kind_d = KIND_OVERFLOW;
			end
		endcase
	end

	assign load = !q_empty && (!vld_q || pop);
	assign q_rd = load;

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (pop) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_d;
			data_q <= data_d;
			idx_q  <= idx_d;
			id_q   <= q_rdata.id;
			len_q  <= q_rdata.len;
		end
	end

	assign empty         = !vld_q;
	assign kind          = kind_q;
	assign data_byte     = data_q;
	assign payload_index = idx_q;
	assign message_id    = id_q;
	assign frame_length  = len_q;

endmodule

### hdl/sync_length_xor_frame_parser.sv
// Sync/length/XOR frame parser for a received serial byte stream.
// Input side is a queue write port: push one rx_byte per cycle while full is low.
// Result side is a queue read port: a result sits on kind, data_byte,
// payload_index, message_id and frame_length while empty is low; pop takes it.
// Each payload byte yields a kind-0 result with its index; the checksum byte
// yields frame good or checksum failure; a position past POSITION_LIMIT yields
// overflow. Sync and header bytes yield no result.
// A result passes from its accepting edge into a queue entry and from there into
// the output register, which loads it once that register is empty or being popped.
// Throughput: one byte per cycle while full is low; the front end updates the
// position and XOR for every accepted byte.
// The queue of QUEUE_DEPTH records plus the output register absorb a stalled
// receiver; once the queue fills, full rises and input bytes wait.
// Reset clears the parser to hunting, empties the queue and output register,
// and loads sync_value with 0xA4. sync_value is at APB byte address 0.
// Depends on slxfp_pkg, slxfp_front, slxfp_queue, slxfp_back.
`include "sync_length_xor_frame_parser_defines.svh"
module sync_length_xor_frame_parser import slxfp_pkg::*; #(
	parameter int unsigned POSITION_LIMIT = 32,
	parameter int unsigned QUEUE_DEPTH    = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	// input bytes
	input  logic                  push,
	output logic                  full,
	input  logic [BYTE_W-1:0]     rx_byte,
	// results
	output logic                  empty,
	input  logic                  pop,
	output logic [1:0]            kind,
	output logic [BYTE_W-1:0]     data_byte,
	output logic [BYTE_W-1:0]     payload_index,
	output logic [BYTE_W-1:0]     message_id,
	output logic [BYTE_W-1:0]     frame_length
);

	logic [BYTE_W-1:0] sync_q;
	logic              accept;
	logic              q_wr, q_rd, q_full, q_empty;
	fe_rec_t           q_rec, q_rdata;
	fe_stat_t          fe_stat;
	kind_t             kind_w;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[CFG_ADDR_W-1] == REG_SYNC) ? CFG_DATA_W'(sync_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[CFG_ADDR_W-1] == REG_SYNC)) begin
			sync_q <= pwdata[BYTE_W-1:0];
		end
	end

	assign full   = q_full;
	assign accept = push && !q_full;

	slxfp_front #(
		.POSITION_LIMIT(POSITION_LIMIT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sync_value(sync_q),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.rec_wr    (q_wr),
		.rec       (q_rec),
		.stat      (fe_stat)
	);

	slxfp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_wr),
		.wdata (q_rec),
		.full  (q_full),
		.rd    (q_rd),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	slxfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_rdata      (q_rdata),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.kind         (kind_w),
		.data_byte    (data_byte),
		.payload_index(payload_index),
		.message_id   (message_id),
		.frame_length (frame_length)
	);

	assign kind = kind_w;

	// Header bytes never produce a record
	`SLXFP_ASSERT(a_hdr_no_rec, (accept && fe_stat.in_header) |-> !q_wr, "header byte record")
	// Frame end and overflow return the parser to hunting
	`SLXFP_ASSERT(a_end_hunts, (q_wr && (q_rec.cls != CLS_PAYLOAD)) |=> fe_stat.hunting, "no hunt")
	// Never write a full queue
	`SLXFP_ASSERT_ALWAYS(a_no_overrun, !(q_full && q_wr), "record written into full queue")

endmodule

### dv/testbench.sv
// Testbench for the sync/length/XOR frame parser: byte stream in, parsed results out.
// Predicts every result from its own copy of the parser state and checks it field by field.
// Depends on slxfp_pkg and sync_length_xor_frame_parser.
`timescale 1ns / 1ps

module testbench import slxfp_pkg::*; ();

	localparam int POS_LIMIT      = 32;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int QUIET_ITEMS    = 250;
	localparam int PHASE_ITEMS    = 400;
	localparam int LATENCY_PAD    = 6;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] idx;
		logic [7:0] id;
		logic [7:0] len;
	} parse_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	logic [7:0] rx_byte = 8'h00;
	logic empty;
	logic pop = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] payload_index;
	logic [7:0] message_id;
	logic [7:0] frame_length;

	// Parser state as the block should hold it
	logic [7:0] cur_sync = SYNC_RESET;
	logic [7:0] frame_pos = POS_HUNT;
	logic [7:0] frame_xor = 8'h00;
	logic [7:0] frame_len = 8'h00;
	logic [7:0] frame_id = 8'h00;

	parse_result_t expected_results[$];
	int errors = 0;
	int item_count = 0;
	int idle_cycles = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit hold_req = 1'b0;
	int hold_len = HOLD_CYCLES;

	sync_length_xor_frame_parser #(.POSITION_LIMIT(POS_LIMIT)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .rx_byte(rx_byte),
		.empty(empty), .pop(pop), .kind(kind), .data_byte(data_byte),
		.payload_index(payload_index), .message_id(message_id),
		.frame_length(frame_length)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Advance the parser by one accepted byte and queue the result it causes
	function automatic void parse_byte(input logic [7:0] b);
		parse_result_t r;
		if (frame_pos == POS_HUNT) begin
			if (b == cur_sync) begin
				frame_xor = b;
				frame_pos = POS_LEN;
			end else begin
				frame_xor = 8'h00;
			end
			return;
		end
		frame_xor = frame_xor ^ b;
		if (frame_pos == POS_LEN) begin
			frame_len = b;
			frame_pos = POS_ID;
			return;
		end
		if (frame_pos == POS_ID) begin
			frame_id = b;
			frame_pos = HDR_BYTES;
			return;
		end
		r.id = frame_id;
		r.len = frame_len;
		r.idx = 8'h00;
		r.data = 8'h00;
		if (int'(frame_pos) > POS_LIMIT) begin
			r.kind = KIND_OVERFLOW;
			frame_pos = POS_HUNT;
			frame_xor = 8'h00;
		end else if (int'(frame_pos) == int'(frame_len) + int'(HDR_BYTES)) begin
			if (frame_xor == 8'h00) begin
				r.kind = KIND_GOOD;
				r.data = b;
			end else begin
				r.kind = KIND_BADSUM;
			end
			frame_pos = POS_HUNT;
			frame_xor = 8'h00;
		end else begin
			r.kind = KIND_PAYLOAD;
			r.data = b;
			r.idx = frame_pos - HDR_BYTES;
			frame_pos = frame_pos + 8'd1;
			if (frame_pos == POS_HUNT)
				frame_xor = 8'h00;
		end
		expected_results.push_back(r);
	endfunction

	// Offer one byte, with an occasional gap before it, and hold it until taken
	task automatic send_item(input logic [7:0] b);
		if (tx_idle_on && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		parse_byte(b);
		item_count++;
	endtask

	// Send sync, length, id, payload and checksum; corrupt flips checksum bits.
	// A frame past the position limit gets one trailing byte that trips overflow.
	task automatic send_frame(input logic [7:0] len, input logic [7:0] id,
			input int fill, input logic [7:0] corrupt);
		logic [7:0] sum;
		logic [7:0] b;
		int n;
		bit too_long;
		too_long = int'(len) + 3 > POS_LIMIT;
		n = too_long ? POS_LIMIT - 2 : int'(len);
		sum = cur_sync ^ len ^ id;
		send_item(cur_sync);
		send_item(len);
		send_item(id);
		for (int i = 0; i < n; i++) begin
			if (fill >= 0)
				b = fill[7:0];
			else if ($urandom_range(0, 15) == 0)
				b = cur_sync;
			else
				b = 8'($urandom);
			sum = sum ^ b;
			send_item(b);
		end
		if (too_long)
			send_item(8'($urandom));
		else
			send_item(sum ^ corrupt);
	endtask

	// Stop offering, wait for every expected result, then let the pipeline settle
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	// Write the sync register over the configuration port once the block is idle,
	// then read it back
	task automatic write_sync(input logic [7:0] v);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(4 * REG_SYNC);
		pwdata <= CFG_DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_sync = v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== CFG_DATA_W'(v) || pready !== 1'b1) begin
			$display("%0t: sync_value readback mismatch: expected %08h, actual %08h",
				$time, CFG_DATA_W'(v), prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed_frames();
		// noise while hunting
		send_item(8'h00);
		send_item(8'hFF);
		send_item(8'h5A);
		send_frame(8'd0, 8'hFF, -1, 8'h00);
		send_frame(8'd2, 8'h00, 8'hFF, 8'h00);
		send_frame(8'd1, 8'hA4, 8'h00, 8'h80);
		// sync value inside the payload is plain data
		send_frame(8'd3, 8'h7E, int'(SYNC_RESET), 8'h00);
		drain();
	endtask

	task automatic test_position_limit();
		// longest frame that still fits, then two that overflow
		send_frame(8'(POS_LIMIT - 3), 8'h11, -1, 8'h00);
		send_frame(8'(POS_LIMIT - 2), 8'h22, -1, 8'h00);
		send_frame(8'd255, 8'h33, -1, 8'h00);
		drain();
	endtask

	task automatic test_sync_values();
		write_sync(8'h00);
		send_item(8'hFF);
		send_frame(8'd2, 8'h01, -1, 8'h00);
		send_frame(8'd1, 8'h02, -1, 8'h01);
		write_sync(8'hFF);
		send_item(8'h00);
		send_item(8'hA4);
		send_frame(8'd3, 8'hFF, -1, 8'h00);
		write_sync(8'($urandom));
		send_frame(8'd4, 8'h5C, -1, 8'h00);
		write_sync(SYNC_RESET);
	endtask

	task automatic test_backpressure();
		// hold the receiver off while two long frames pile up behind it
		hold_len = HOLD_CYCLES;
		hold_req = 1'b1;
		send_frame(8'd25, 8'h44, -1, 8'h00);
		send_frame(8'd20, 8'h55, -1, 8'h00);
		drain();
	endtask

	task automatic test_random_stream();
		int base;
		int phase;
		int pick;
		logic [7:0] len;
		logic [7:0] corrupt;
		base = item_count;
		phase = 0;
		while (item_count - base < RANDOM_ITEMS) begin
			if (item_count - base >= RANDOM_ITEMS - QUIET_ITEMS) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end else if (item_count - base >= (phase + 1) * PHASE_ITEMS) begin
				phase++;
				write_sync(8'($urandom));
				tx_idle_on = $urandom_range(0, 3) != 0;
				rx_idle_on = $urandom_range(0, 3) != 0;
			end
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				// line noise
				repeat ($urandom_range(1, 3)) send_item(8'($urandom));
			end else if (pick == 1) begin
				// broken frame: sync and a few bytes, then the next frame cuts in
				send_item(cur_sync);
				repeat ($urandom_range(0, 4)) send_item(8'($urandom));
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					len = 8'($urandom_range(0, 8));
				else if (pick < 9)
					len = 8'($urandom_range(9, POS_LIMIT - 3));
				else if ($urandom_range(0, 3) == 0)
					len = 8'd255;
				else
					len = 8'($urandom_range(POS_LIMIT - 2, 60));
				corrupt = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
				send_frame(len, 8'($urandom), -1, corrupt);
			end
		end
	endtask

	// Receiver: pop in random stretches, idle in bursts, and take long hold-offs on request
	initial begin : result_receiver
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				pop <= 1'b0;
				hold_req = 1'b0;
				n = 0;
				while (n < hold_len) begin
					@(posedge clk);
					n++;
				end
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare each popped result with the oldest prediction
	always @(posedge clk) begin : result_check
		parse_result_t r;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual kind %0d data %02h",
					$time, kind, data_byte);
				errors++;
			end else begin
				r = expected_results.pop_front();
				check_field("kind", 8'(r.kind), 8'(kind));
				check_field("data_byte", r.data, data_byte);
				check_field("payload_index", r.idx, payload_index);
				check_field("message_id", r.id, message_id);
				check_field("frame_length", r.len, frame_length);
			end
		end
	end

	// End the run when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_position_limit();
		test_sync_values();
		test_backpressure();
		test_random_stream();
		drain();
		if (errors == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
